### hdl/plit_pkg.sv
// ----------------------------------------------------------------------------
// plit_pkg: shared types, codes and microcode for the interpolation table
// Control-word layout, status codes and the read-only sequencer program.
// ----------------------------------------------------------------------------
package plit_pkg;

    localparam int ENTRY_W = 5;
    localparam int VALUE_W = 32;
    localparam int UPC_W   = 4;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W  = 6;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef logic [UPC_W-1:0] upc_t;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_APPEND,
        OP_QINIT,
        OP_READ,
        OP_TEST,
        OP_LOAD_B,
        OP_DIFF,
        OP_MUL,
        OP_DINIT,
        OP_DSTEP,
        OP_OUT_INTERP,
        OP_OUT_B,
        OP_OUT_A,
        OP_OUT_EMPTY
    } op_t;

    // branch condition: taken -> target, else fall through
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_QUERY,
        C_EMPTY,
        C_IDX_END,
        C_X_LT,
        C_IDX_ZERO,
        C_DIV_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // program addresses
    localparam upc_t U_IDLE     = 4'd0;
    localparam upc_t U_DISPATCH = 4'd1;
    localparam upc_t U_APPEND   = 4'd2;
    localparam upc_t U_QSTART   = 4'd3;
    localparam upc_t U_SCAN     = 4'd4;
    localparam upc_t U_TEST     = 4'd5;
    localparam upc_t U_FOUND    = 4'd6;
    localparam upc_t U_DIFF     = 4'd7;
    localparam upc_t U_MUL      = 4'd8;
    localparam upc_t U_DINIT    = 4'd9;
    localparam upc_t U_DIV      = 4'd10;
    localparam upc_t U_OUT_INT  = 4'd11;
    localparam upc_t U_FIRST    = 4'd12;
    localparam upc_t U_PAST     = 4'd13;
    localparam upc_t U_EMPTY    = 4'd14;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        begin
            unique case (addr)
                U_IDLE:     w = '{OP_LATCH,      C_NO_START, U_IDLE};
                U_DISPATCH: w = '{OP_NOP,        C_QUERY,    U_QSTART};
                U_APPEND:   w = '{OP_APPEND,     C_ALWAYS,   U_IDLE};
                U_QSTART:   w = '{OP_QINIT,      C_EMPTY,    U_EMPTY};
                U_SCAN:     w = '{OP_READ,       C_IDX_END,  U_PAST};
                U_TEST:     w = '{OP_TEST,       C_X_LT,     U_SCAN};
                U_FOUND:    w = '{OP_LOAD_B,     C_IDX_ZERO, U_FIRST};
                U_DIFF:     w = '{OP_DIFF,       C_NEVER,    U_IDLE};
                U_MUL:      w = '{OP_MUL,        C_NEVER,    U_IDLE};
                U_DINIT:    w = '{OP_DINIT,      C_NEVER,    U_IDLE};
                U_DIV:      w = '{OP_DSTEP,      C_DIV_MORE, U_DIV};
                U_OUT_INT:  w = '{OP_OUT_INTERP, C_ALWAYS,   U_IDLE};
                U_FIRST:    w = '{OP_OUT_B,      C_ALWAYS,   U_IDLE};
                U_PAST:     w = '{OP_OUT_A,      C_ALWAYS,   U_IDLE};
                U_EMPTY:    w = '{OP_OUT_EMPTY,  C_ALWAYS,   U_IDLE};
                default:    w = '{OP_NOP,        C_ALWAYS,   U_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

### hdl/piecewise_linear_interp_table.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table: breakpoint table with linear interpolation
// Appends (x,y) breakpoints and answers interpolated queries in signed Q16.16.
// ----------------------------------------------------------------------------
// Append beat: start is latched in the idle step; dispatch and the append step
//   follow, busy through both, and done is registered from the append step.
// Interpolating query: busy through dispatch, a read and a test per scanned entry,
//   the span setup, the multiply, the 32-step serial divide and the output step.
// One beat at a time: the next start is taken in the cycle done is high.
// done is a one-cycle strobe; the receiver has no way to hold it off.
// Reset empties the table (count = 0) and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_table
    import plit_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      kind,
    input  logic signed [VALUE_W-1:0] x_value,
    input  logic signed [VALUE_W-1:0] y_value,
    output logic                      done,
    output logic signed [VALUE_W-1:0] y_result,
    output logic [ENTRY_W-1:0]        entry_index,
    output logic [1:0]                status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Breakpoint store: one write port, one registered read port.
    // Entries at or above the count are never read.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] x_mem [DEPTH];
    logic signed [VALUE_W-1:0] y_mem [DEPTH];
    logic signed [VALUE_W-1:0] x_rd_reg;
    logic signed [VALUE_W-1:0] y_rd_reg;
    logic                      mem_we;
    logic                      mem_re;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    upc_t                       upc_reg, upc_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       done_reg, done_next;

    logic                       kind_reg, kind_next;
    logic signed [VALUE_W-1:0]  q_reg, q_next;        // query x or append x
    logic signed [VALUE_W-1:0]  yin_reg, yin_next;    // append y
    logic [CNT_W-1:0]           idx_reg, idx_next;    // scan position
    logic signed [VALUE_W-1:0]  xa_reg, xa_next;      // entry below query
    logic signed [VALUE_W-1:0]  ya_reg, ya_next;
    logic signed [VALUE_W-1:0]  xb_reg, xb_next;      // first entry at/above
    logic signed [VALUE_W-1:0]  yb_reg, yb_next;
    logic [VALUE_W-1:0]         span_reg, span_next;  // xb - xa, positive
    logic [VALUE_W-1:0]         off_reg, off_next;    // q - xa, in (0, span]
    logic [VALUE_W-1:0]         mag_reg, mag_next;    // |yb - ya|
    logic                       neg_reg, neg_next;    // yb below ya
    logic [2*VALUE_W-1:0]       prod_reg, prod_next;
    logic [VALUE_W-1:0]         rem_reg, rem_next;
    logic [VALUE_W-1:0]         quo_reg, quo_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;

    logic signed [VALUE_W-1:0]  y_result_reg, y_result_next;
    logic [ENTRY_W-1:0]         entry_index_reg, entry_index_next;
    logic [1:0]                 status_reg, status_next;

    uword_t                     uw;
    logic                       cond_hit;
    logic                       full;
    logic                       x_lt;

    // subtractor and divider helpers
    logic [VALUE_W:0]           d_span, d_off, d_rise, d_fall;
    logic [VALUE_W:0]           rem_sh;
    logic [VALUE_W:0]           rem_try;

    assign uw    = ucode_rom(upc_reg);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign x_lt  = (x_rd_reg < q_reg);
    assign busy  = (upc_reg != U_IDLE);

    assign done        = done_reg;
    assign y_result    = y_result_reg;
    assign entry_index = entry_index_reg;
    assign status      = status_reg;

    // ------------------------------------------------------------------
    // Branch condition and next micro address
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_NO_START: cond_hit = !start;
            C_QUERY:    cond_hit = kind_reg;
            C_EMPTY:    cond_hit = (count_reg == '0);
            C_IDX_END:  cond_hit = (idx_reg == count_reg);
            C_X_LT:     cond_hit = x_lt;
            C_IDX_ZERO: cond_hit = (idx_reg == '0);
            C_DIV_MORE: cond_hit = (dcnt_reg != DCNT_W'(1));
            default:    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic shared by the steps (33-bit differences, divide step)
    // ------------------------------------------------------------------
    assign d_span = {xb_reg[VALUE_W-1], xb_reg} - {xa_reg[VALUE_W-1], xa_reg};
    assign d_off  = {q_reg[VALUE_W-1], q_reg}   - {xa_reg[VALUE_W-1], xa_reg};
    assign d_rise = {yb_reg[VALUE_W-1], yb_reg} - {ya_reg[VALUE_W-1], ya_reg};
    assign d_fall = {ya_reg[VALUE_W-1], ya_reg} - {yb_reg[VALUE_W-1], yb_reg};

    // restoring divide: one quotient bit a cycle
    assign rem_sh  = {rem_reg, quo_reg[VALUE_W-1]};
    assign rem_try = rem_sh - {1'b0, span_reg};

    // ------------------------------------------------------------------
    // Control word decode: datapath actions of the current step
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        done_next        = 1'b0;
        kind_next        = kind_reg;
        q_next           = q_reg;
        yin_next         = yin_reg;
        idx_next         = idx_reg;
        xa_next          = xa_reg;
        ya_next          = ya_reg;
        xb_next          = xb_reg;
        yb_next          = yb_reg;
        span_next        = span_reg;
        off_next         = off_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dcnt_next        = dcnt_reg;
        y_result_next    = y_result_reg;
        entry_index_next = entry_index_reg;
        status_next      = status_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        unique case (uw.op)
            OP_NOP:
            begin
            end
            OP_LATCH:
            begin
                if (start)
                begin
                    kind_next = kind;
                    q_next    = x_value;
                    yin_next  = y_value;
                end
            end
            OP_APPEND:
            begin
                done_next     = 1'b1;
                y_result_next = '0;
                if (full)
                begin
                    entry_index_next = '0;
                    status_next      = STATUS_FULL;
                end
                else
                begin
                    mem_we           = 1'b1;
                    entry_index_next = ENTRY_W'(count_reg);
                    status_next      = STATUS_OK;
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            OP_QINIT:
            begin
                idx_next = '0;
            end
            OP_READ:
            begin
                mem_re = (idx_reg != count_reg);
            end
            OP_TEST:
            begin
                if (x_lt)
                begin
                    xa_next  = x_rd_reg;
                    ya_next  = y_rd_reg;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            OP_LOAD_B:
            begin
                xb_next = x_rd_reg;
                yb_next = y_rd_reg;
            end
            OP_DIFF:
            begin
                span_next = d_span[VALUE_W-1:0];
                off_next  = d_off[VALUE_W-1:0];
                neg_next  = d_rise[VALUE_W];
                mag_next  = d_rise[VALUE_W] ? d_fall[VALUE_W-1:0] : d_rise[VALUE_W-1:0];
            end
            OP_MUL:
            begin
                prod_next = mag_reg * off_reg;
            end
            OP_DINIT:
            begin
                // quotient fits 32 bits, so the high half is already below span
                rem_next  = prod_reg[2*VALUE_W-1:VALUE_W];
                quo_next  = prod_reg[VALUE_W-1:0];
                dcnt_next = DCNT_W'(DIV_STEPS);
            end
            OP_DSTEP:
            begin
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (!rem_try[VALUE_W])
                begin
                    rem_next = rem_try[VALUE_W-1:0];
                    quo_next = {quo_reg[VALUE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[VALUE_W-1:0];
                    quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
                end
            end
            OP_OUT_INTERP:
            begin
                done_next        = 1'b1;
                y_result_next    = neg_reg ? (ya_reg - $signed(quo_reg))
                                           : (ya_reg + $signed(quo_reg));
                entry_index_next = '0;
                status_next      = STATUS_OK;
            end
            OP_OUT_B:
            begin
                // query at or below the first x
                done_next        = 1'b1;
                y_result_next    = yb_reg;
                entry_index_next = '0;
                status_next      = STATUS_OK;
            end
            OP_OUT_A:
            begin
                // query past the last x: ya holds the last stored y
                done_next        = 1'b1;
                y_result_next    = ya_reg;
                entry_index_next = '0;
                status_next      = STATUS_OK;
            end
            OP_OUT_EMPTY:
            begin
                done_next        = 1'b1;
                y_result_next    = '0;
                entry_index_next = '0;
                status_next      = STATUS_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Breakpoint memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[count_reg[IDX_W-1:0]] <= q_reg;
            y_mem[count_reg[IDX_W-1:0]] <= yin_reg;
        end
        if (mem_re)
        begin
            x_rd_reg <= x_mem[idx_reg[IDX_W-1:0]];
            y_rd_reg <= y_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg   <= U_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            upc_reg   <= upc_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        q_reg           <= q_next;
        yin_reg         <= yin_next;
        idx_reg         <= idx_next;
        xa_reg          <= xa_next;
        ya_reg          <= ya_next;
        xb_reg          <= xb_next;
        yb_reg          <= yb_next;
        span_reg        <= span_next;
        off_reg         <= off_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        dcnt_reg        <= dcnt_next;
        y_result_reg    <= y_result_next;
        entry_index_reg <= entry_index_next;
        status_reg      <= status_next;
    end

endmodule

### tb/plit_test_pkg.sv
// ----------------------------------------------------------------------------
// plit_test_pkg: testbench codes for the interpolation table test
// Item kind codes and the table depth shared by stimulus and checker.
// ----------------------------------------------------------------------------
package plit_test_pkg;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam int TABLE_DEPTH = 32;

endpackage

### tb/interp_table_checker.sv
// ----------------------------------------------------------------------------
// interp_table_checker: answer predictor and comparator for the table
// Mirrors the breakpoint table, predicts every beat's answer, checks done.
// ----------------------------------------------------------------------------
module interp_table_checker
    import plit_pkg::*;
    import plit_test_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      kind,
    input  logic signed [VALUE_W-1:0] x_value,
    input  logic signed [VALUE_W-1:0] y_value,
    input  logic                      done,
    input  logic signed [VALUE_W-1:0] y_result,
    input  logic [ENTRY_W-1:0]        entry_index,
    input  logic [1:0]                status,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct {
        logic signed [VALUE_W-1:0] y;
        logic [ENTRY_W-1:0]        idx;
        logic [1:0]                st;
    } answer_t;

    logic signed [VALUE_W-1:0] bp_x [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] bp_y [TABLE_DEPTH];
    int                        bp_count;
    answer_t                   owed_answers[$];
    answer_t                   head;

    // one beat against the mirrored table; appends update it
    function automatic answer_t table_answer(input logic k,
                                             input logic signed [VALUE_W-1:0] xv,
                                             input logic signed [VALUE_W-1:0] yv);
        answer_t     r;
        int          pos;
        longint      xa, xb, ya, yb, span, off, rise;
        logic [63:0] mag, quo, res;
        begin
            r.y   = '0;
            r.idx = '0;
            r.st  = STATUS_OK;
            if (k == KIND_APPEND) begin
                if (bp_count < TABLE_DEPTH) begin
                    bp_x[bp_count] = xv;
                    bp_y[bp_count] = yv;
                    r.idx = bp_count[ENTRY_W-1:0];
                    bp_count++;
                end else begin
                    r.st = STATUS_FULL;
                end
            end else if (bp_count == 0) begin
                r.st = STATUS_EMPTY;
            end else begin
                pos = 0;
                while (pos < bp_count && bp_x[pos] < xv)
                    pos++;
                if (pos == 0) begin
                    r.y = bp_y[0];
                end else if (pos >= bp_count) begin
                    r.y = bp_y[bp_count-1];
                end else begin
                    xa   = bp_x[pos-1];
                    xb   = bp_x[pos];
                    ya   = bp_y[pos-1];
                    yb   = bp_y[pos];
                    span = xb - xa;
                    off  = longint'(xv) - xa;
                    rise = yb - ya;
                    // magnitude times offset at full width, truncating divide
                    mag  = (rise < 0) ? -rise : rise;
                    mag  = mag * 64'(off);
                    quo  = mag / 64'(span);
                    res  = (rise < 0) ? ya - quo : ya + quo;
                    r.y  = res[VALUE_W-1:0];
                end
            end
            return r;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            bp_count = 0;
            owed_answers.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            // a done in the same cycle as a new start belongs to the older beat
            if (done) begin
                if (owed_answers.size() == 0) begin
                    $error("done with no beat outstanding");
                    mismatches++;
                end else begin
                    head = owed_answers.pop_front();
                    if (y_result !== head.y) begin
                        $error("y_result: expected %0d, got %0d", head.y, y_result);
                        mismatches++;
                    end
                    if (entry_index !== head.idx) begin
                        $error("entry_index: expected %0d, got %0d", head.idx, entry_index);
                        mismatches++;
                    end
                    if (status !== head.st) begin
                        $error("status: expected %0d, got %0d", head.st, status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                owed_answers.push_back(table_answer(kind, x_value, y_value));
            outstanding = owed_answers.size();
        end
    end

endmodule

### tb/piecewise_linear_interp_table_test.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table_test: top of the interpolation table test
// Drives append and query beats, with a checker predicting every answer.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_table_test;
    import plit_pkg::*;
    import plit_test_pkg::*;

    // random beats after the directed opening; three idle phases over them
    localparam int RANDOM_BEATS = 1830;
    // the slowest beat scans the table and runs the serial divide; ~1850 beats fit well inside
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [VALUE_W-1:0] X_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] X_MAX = 32'h7fff_ffff;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      kind;
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] y_value;
    logic                      done;
    logic signed [VALUE_W-1:0] y_result;
    logic [ENTRY_W-1:0]        entry_index;
    logic [1:0]                status;

    int                        mismatches;
    int                        outstanding;
    int                        cycle_count;
    int                        idle_pct;

    // x of every stored breakpoint, for aiming queries at and around them
    logic [VALUE_W-1:0]        stored_x[$];
    // last breakpoint of the ascending run; appends mostly climb from here
    int                        last_x;
    logic [VALUE_W-1:0]        bx, by, qx, pick;
    int                        n;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    piecewise_linear_interp_table #(.DEPTH(TABLE_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .y_result    (y_result),
        .entry_index (entry_index),
        .status      (status)
    );

    interp_table_checker answer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .y_result    (y_result),
        .entry_index (entry_index),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // One beat. Called at a falling edge; returns at the falling edge after
    // the beat is taken. start stays high across back-to-back beats.
    task automatic issue(input logic k, input logic [VALUE_W-1:0] xv,
                         input logic [VALUE_W-1:0] yv);
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                // idle cycle: fields are junk the block must ignore
                start   = 1'b0;
                x_value = $urandom;
                y_value = $urandom;
                @(negedge clk);
            end
            start   = 1'b1;
            kind    = k;
            x_value = xv;
            y_value = yv;
            if (k == KIND_APPEND && stored_x.size() < TABLE_DEPTH)
                stored_x.push_back(xv);
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
    endtask

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        kind     = KIND_APPEND;
        x_value  = '0;
        y_value  = '0;
        idle_pct = 12;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed opening ----
        // empty table: query gives 0 with empty status
        issue(KIND_QUERY, '0, $urandom);
        issue(KIND_QUERY, X_MAX, $urandom);
        // entry 0 at the most negative x, holding the largest y
        issue(KIND_APPEND, X_MIN, X_MAX);
        issue(KIND_QUERY, X_MIN, $urandom);       // at first x
        issue(KIND_QUERY, '0, $urandom);          // past last, one entry
        // entry 1: y drops from max to min, the widest possible rise
        issue(KIND_APPEND, -32'sd1000 * 65536, X_MIN);
        issue(KIND_QUERY, X_MIN + 1, $urandom);   // offset of one over a huge span
        issue(KIND_QUERY, -32'sd1000 * 65536 - 1, $urandom);
        issue(KIND_QUERY, -32'sd1000 * 65536, $urandom);   // exactly on entry 1
        issue(KIND_QUERY, 32'hc000_0000, $urandom);
        // out of order entry, then a duplicate x of entry 1
        issue(KIND_APPEND, -32'sd2000 * 65536, '0);
        issue(KIND_APPEND, -32'sd1000 * 65536, 32'h1234_5678);
        issue(KIND_QUERY, -32'sd1000 * 65536 + 1, $urandom);  // scans past all
        issue(KIND_QUERY, X_MAX, $urandom);
        // short span above the duplicate, rising slope
        issue(KIND_APPEND, -32'sd999 * 65536, X_MAX);
        issue(KIND_QUERY, -32'sd1000 * 65536 + 32'sh8000, $urandom);
        issue(KIND_QUERY, -32'sd1000 * 65536, $urandom);   // stops on first match
        last_x = -999 * 65536;

        // ---- random part ----
        // fills the table while querying it at every size, then hammers the
        // full table with queries and dropped appends
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
                idle_pct = 66;
            else if (n == 2 * RANDOM_BEATS / 3)
                idle_pct = 0;

            if ($urandom_range(0, (stored_x.size() < TABLE_DEPTH) ? 6 : 11) == 0)
            begin
                if (stored_x.size() >= TABLE_DEPTH)
                begin
                    bx = $urandom;
                end
                else
                begin
                    // increments are capped so the ascending run cannot wrap
                    case ($urandom_range(0, 9))
                        0: bx = $urandom;                 // out of order
                        1: bx = last_x;                   // duplicate x
                        2:
                        begin
                            last_x += $urandom_range(1, 3);
                            bx = last_x;
                        end
                        default:
                        begin
                            last_x += $urandom_range(1, 1 << 26);
                            bx = last_x;
                        end
                    endcase
                end
                if ($urandom_range(0, 7) == 0)
                    by = $urandom_range(0, 1) ? X_MAX : X_MIN;
                else
                    by = $urandom;
                issue(KIND_APPEND, bx, by);
            end
            else
            begin
                pick = stored_x[$urandom_range(0, stored_x.size() - 1)];
                case ($urandom_range(0, 9))
                    0, 1, 2: qx = $urandom;
                    3, 4:    qx = pick;
                    5, 6:    qx = pick + $urandom_range(0, 6) - 3;
                    7:       qx = pick + $urandom_range(0, 1 << 24);
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0:       qx = X_MIN;
                            1:       qx = X_MAX;
                            2:       qx = '0;
                            default: qx = '1;
                        endcase
                    end
                    default: qx = last_x + $urandom_range(1, 1 << 20);
                endcase
                issue(KIND_QUERY, qx, $urandom);
            end
        end
        start = 1'b0;

        // drain, then leave room for any stray done
        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * TABLE_DEPTH + 60) @(negedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
